/* rtl/cdl_pkg.sv */
// ============================================================================
// Class-data decoder package
// Shared widths, record kind codes and the types passed between the
// LEB128 step unit, the parser and the output register.
// ============================================================================
package cdl_pkg;

    localparam int DATA_W         = 32;
    localparam int KIND_W         = 3;

    // Longest legal LEB128 encoding, in bytes.
    localparam int MAX_LEB_BYTES  = 5;
    localparam int LEB_CNT_W      = $clog2(MAX_LEB_BYTES + 1);
    localparam int LEB_GROUP_BITS = 7;
    // Number of seven-bit groups that still land below bit 32.
    localparam int LEB_GROUPS     = (DATA_W + LEB_GROUP_BITS - 1) / LEB_GROUP_BITS;
    localparam int LEB_SHIFT_W    = 6;

    localparam logic [KIND_W-1:0] KIND_HEADER   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STATIC   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INSTANCE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIRECT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_VIRTUAL  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ENDED    = 3'd5;

    typedef struct packed {
        logic [DATA_W-1:0]    acc;
        logic [LEB_CNT_W-1:0] cnt;
        logic                 done;
        logic                 overlong;
    } t_leb_res;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] member_index;
        logic [DATA_W-1:0] access_flags;
        logic [DATA_W-1:0] code_off;
        logic [DATA_W-1:0] static_count;
        logic [DATA_W-1:0] instance_count;
        logic [DATA_W-1:0] direct_count;
        logic [DATA_W-1:0] virtual_count;
        logic              last;
        logic              overlong;
    } t_record;

endpackage

/* rtl/cdl_leb_step.sv */
// ============================================================================
// LEB128 byte step
// Folds one byte into a partial unsigned LEB128 value: seven payload bits
// placed at the current group position, continuation and length check.
// ============================================================================
module cdl_leb_step (
    input  logic [cdl_pkg::DATA_W-1:0]    i_acc,
    input  logic [cdl_pkg::LEB_CNT_W-1:0] i_cnt,
    input  logic [7:0]                    i_byte,
    output cdl_pkg::t_leb_res             o_res
);

    logic [cdl_pkg::LEB_SHIFT_W-1:0] shift;
    logic [cdl_pkg::DATA_W-1:0]      group;
    logic [cdl_pkg::LEB_CNT_W-1:0]   cnt_inc;

    assign shift   = cdl_pkg::LEB_SHIFT_W'(cdl_pkg::LEB_GROUP_BITS * int'(i_cnt));
    assign cnt_inc = i_cnt + cdl_pkg::LEB_CNT_W'(1);

    // Groups at or above bit 32 are dropped; the straddling group is truncated.
    always_comb begin
        if (int'(i_cnt) < cdl_pkg::LEB_GROUPS) begin
            group = {{(cdl_pkg::DATA_W-7){1'b0}}, i_byte[6:0]} << shift;
        end else begin
            group = '0;
        end
    end

    assign o_res.acc      = i_acc | group;
    assign o_res.cnt      = cnt_inc;
    assign o_res.done     = !i_byte[7];
    assign o_res.overlong = i_byte[7] && (int'(cnt_inc) >= cdl_pkg::MAX_LEB_BYTES);

endmodule

/* rtl/cdl_parser.sv */
// ============================================================================
// Class-data parser
// Holds the decode state of one class-data item and, for each byte step,
// works out the next state and at most one record.
// ============================================================================
module cdl_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_restart,
    output logic              o_rec_valid,
    output cdl_pkg::t_record  o_rec
);

    typedef enum logic [2:0] {
        PH_HEADER   = cdl_pkg::KIND_HEADER,
        PH_STATIC   = cdl_pkg::KIND_STATIC,
        PH_INSTANCE = cdl_pkg::KIND_INSTANCE,
        PH_DIRECT   = cdl_pkg::KIND_DIRECT,
        PH_VIRTUAL  = cdl_pkg::KIND_VIRTUAL,
        PH_DONE     = cdl_pkg::KIND_ENDED
    } t_phase;

    t_phase                          r_phase, n_phase, cur_phase, nxt_list;
    logic [cdl_pkg::LEB_CNT_W-1:0]   r_cnt, n_cnt, cur_cnt;
    logic [cdl_pkg::DATA_W-1:0]      r_acc, n_acc, cur_acc;
    logic [1:0]                      r_fpos, n_fpos, cur_fpos;
    logic [cdl_pkg::DATA_W-1:0]      r_entries, n_entries, cur_entries;
    logic [cdl_pkg::DATA_W-1:0]      r_counts [4];
    logic [cdl_pkg::DATA_W-1:0]      n_counts [4];
    logic [cdl_pkg::DATA_W-1:0]      cur_counts [4];
    logic [cdl_pkg::DATA_W-1:0]      r_running, n_running, cur_running;
    logic [cdl_pkg::DATA_W-1:0]      r_held_idx, n_held_idx, cur_held_idx;
    logic [cdl_pkg::DATA_W-1:0]      r_held_acc, n_held_acc, cur_held_acc;
    cdl_pkg::t_leb_res               leb;
    logic                            do_emit, do_enter;
    logic [2:0]                      enter_from;
    logic [cdl_pkg::DATA_W-1:0]      emit_code;

    // First list at or after 'from' whose count is nonzero.
    function automatic t_phase f_enter(input logic [cdl_pkg::DATA_W-1:0] c [4],
                                       input logic [2:0] from);
        t_phase res;
        res = PH_DONE;
        for (int k = 4; k >= 1; k--) begin
            if ((from <= 3'(k)) && (c[k-1] != '0)) begin
                res = t_phase'(3'(k));
            end
        end
        return res;
    endfunction

    // A restart byte is decoded against freshly cleared state.
    always_comb begin
        cur_phase    = i_restart ? PH_HEADER : r_phase;
        cur_cnt      = i_restart ? '0 : r_cnt;
        cur_acc      = i_restart ? '0 : r_acc;
        cur_fpos     = i_restart ? '0 : r_fpos;
        cur_entries  = i_restart ? '0 : r_entries;
        cur_running  = i_restart ? '0 : r_running;
        cur_held_idx = i_restart ? '0 : r_held_idx;
        cur_held_acc = i_restart ? '0 : r_held_acc;
        for (int i = 0; i < 4; i++) begin
            cur_counts[i] = i_restart ? '0 : r_counts[i];
        end
    end

    cdl_leb_step u_leb (
        .i_acc  (cur_acc),
        .i_cnt  (cur_cnt),
        .i_byte (i_byte),
        .o_res  (leb)
    );

    always_comb begin
        n_phase    = cur_phase;
        n_cnt      = cur_cnt;
        n_acc      = cur_acc;
        n_fpos     = cur_fpos;
        n_entries  = cur_entries;
        n_running  = cur_running;
        n_held_idx = cur_held_idx;
        n_held_acc = cur_held_acc;
        n_counts   = cur_counts;
        o_rec       = '0;
        o_rec_valid = 1'b0;
        do_emit     = 1'b0;
        do_enter    = 1'b0;
        enter_from  = 3'd1;
        emit_code   = '0;
        nxt_list    = PH_DONE;

        if (cur_phase != PH_DONE) begin
            if (leb.overlong) begin
                o_rec.kind     = 3'(cur_phase);
                o_rec.last     = 1'b1;
                o_rec.overlong = 1'b1;
                o_rec_valid    = 1'b1;
                n_phase        = PH_DONE;
                n_cnt          = '0;
                n_acc          = '0;
                n_fpos         = '0;
            end else if (!leb.done) begin
                n_cnt = leb.cnt;
                n_acc = leb.acc;
            end else begin
                n_cnt = '0;
                n_acc = '0;
                if (cur_phase == PH_HEADER) begin
                    n_counts[cur_fpos] = leb.acc;
                    n_fpos             = cur_fpos + 2'd1;
                    if (cur_fpos == 2'd3) begin
                        do_enter   = 1'b1;
                        enter_from = 3'd1;
                    end
                end else begin
                    case (cur_fpos)
                        2'd0: begin
                            n_held_idx = cur_running + leb.acc;
                            n_running  = cur_running + leb.acc;
                            n_fpos     = 2'd1;
                        end
                        2'd1: begin
                            n_held_acc = leb.acc;
                            if (cur_phase == PH_DIRECT || cur_phase == PH_VIRTUAL) begin
                                n_fpos = 2'd2;
                            end else begin
                                do_emit = 1'b1;
                            end
                        end
                        default: begin
                            do_emit   = 1'b1;
                            emit_code = leb.acc;
                        end
                    endcase
                end
            end
        end

        if (do_emit) begin
            o_rec.kind         = 3'(cur_phase);
            o_rec.member_index = n_held_idx;
            o_rec.access_flags = n_held_acc;
            o_rec.code_off     = emit_code;
            o_rec_valid        = 1'b1;
            n_fpos             = '0;
            n_entries          = cur_entries - cdl_pkg::DATA_W'(1);
            if (n_entries == '0) begin
                do_enter   = 1'b1;
                enter_from = 3'(cur_phase) + 3'd1;
            end
        end

        if (do_enter) begin
            nxt_list = f_enter(n_counts, enter_from);
            n_phase  = nxt_list;
            n_fpos   = '0;
            if (nxt_list != PH_DONE) begin
                n_entries = n_counts[2'(3'(nxt_list) - 3'd1)];
                n_running = '0;
            end else begin
                n_entries = '0;
            end
        end

        // The header record goes out when the fourth count completes.
        if (do_enter && !do_emit) begin
            o_rec.kind           = cdl_pkg::KIND_HEADER;
            o_rec.static_count   = n_counts[0];
            o_rec.instance_count = n_counts[1];
            o_rec.direct_count   = n_counts[2];
            o_rec.virtual_count  = n_counts[3];
            o_rec_valid          = 1'b1;
        end
        if (do_enter) begin
            o_rec.last = (nxt_list == PH_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_cnt      <= '0;
            r_acc      <= '0;
            r_fpos     <= '0;
            r_entries  <= '0;
            r_running  <= '0;
            r_held_idx <= '0;
            r_held_acc <= '0;
            for (int i = 0; i < 4; i++) begin
                r_counts[i] <= '0;
            end
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_acc      <= n_acc;
            r_fpos     <= n_fpos;
            r_entries  <= n_entries;
            r_running  <= n_running;
            r_held_idx <= n_held_idx;
            r_held_acc <= n_held_acc;
            r_counts   <= n_counts;
        end
    end

`ifndef SYNTHESIS
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> (r_fpos == 2'd0 && r_cnt == '0 && r_acc == '0))
        else $error("ended item left partial decode state");

    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HEADER && r_phase != PH_DONE) |-> (r_entries != '0))
        else $error("list phase entered with no entries left");

    // In the header phase the position counts the four list sizes.
    a_code_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fpos == 2'd2 && r_phase != PH_HEADER) |->
            (r_phase == PH_DIRECT || r_phase == PH_VIRTUAL))
        else $error("code offset position outside a method list");
`endif

endmodule

/* rtl/cdl_out_reg.sv */
// ============================================================================
// Result register
// Holds one decoded record until the receiver takes it; a new record can be
// loaded in the cycle the held one leaves.
// ============================================================================
module cdl_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  cdl_pkg::t_record  i_rec,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output cdl_pkg::t_record  o_rec
);

    logic             r_valid;
    cdl_pkg::t_record r_rec;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rec <= i_rec;
        end
    end

endmodule

/* rtl/class_data_leb128_decoder.sv */
// ============================================================================
// Class-data LEB128 decoder
// Decodes a class-data byte stream into a header record and one record per
// field or method entry.
// ============================================================================
// Input channel: one byte per word (i_byte_value, i_restart) on
// i_in_valid / o_in_ready. i_restart = 1 drops the item in progress and
// makes this byte the first byte of a new item.
// Output channel: one record per word on o_out_valid / i_out_ready. Most
// bytes produce no record; a byte that completes the fourth count, an
// entry, or an overlong value produces exactly one.
// Path: an accepted byte lands in the input register; its record is loaded
// into the output register when that byte steps the parser.
// Throughput: one byte per cycle while the output register is free; each
// byte is one pass through the LEB128 step and parser between the two registers.
// After the item ends, bytes are taken and dropped until a restart byte.
// Reset (i_rst_n low, synchronous) clears the decode state and empties both
// registers. When the receiver stalls, the pending record is held, one more
// byte is taken into the input register, and o_in_ready then drops until the
// output register frees.
// ============================================================================
module class_data_leb128_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_byte_value,
    input  logic                        i_restart,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [cdl_pkg::KIND_W-1:0]  o_record_kind,
    output logic [cdl_pkg::DATA_W-1:0]  o_member_index,
    output logic [cdl_pkg::DATA_W-1:0]  o_access_flags,
    output logic [cdl_pkg::DATA_W-1:0]  o_code_off,
    output logic [cdl_pkg::DATA_W-1:0]  o_static_count,
    output logic [cdl_pkg::DATA_W-1:0]  o_instance_count,
    output logic [cdl_pkg::DATA_W-1:0]  o_direct_count,
    output logic [cdl_pkg::DATA_W-1:0]  o_virtual_count,
    output logic                        o_last_record,
    output logic                        o_overlong_error
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_restart;
    logic             out_free;
    logic             step;
    logic             rec_valid;
    cdl_pkg::t_record rec;
    cdl_pkg::t_record out_rec;

    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte    <= i_byte_value;
            r_in_restart <= i_restart;
        end
    end

    cdl_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_restart   (r_in_restart),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    cdl_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && rec_valid),
        .i_rec   (rec),
        .i_ready (i_out_ready),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_rec   (out_rec)
    );

    assign o_record_kind    = out_rec.kind;
    assign o_member_index   = out_rec.member_index;
    assign o_access_flags   = out_rec.access_flags;
    assign o_code_off       = out_rec.code_off;
    assign o_static_count   = out_rec.static_count;
    assign o_instance_count = out_rec.instance_count;
    assign o_direct_count   = out_rec.direct_count;
    assign o_virtual_count  = out_rec.virtual_count;
    assign o_last_record    = out_rec.last;
    assign o_overlong_error = out_rec.overlong;

`ifndef SYNTHESIS
    a_overlong_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overlong_error) |->
            (o_last_record && o_member_index == '0 && o_static_count == '0))
        else $error("overlong record does not end the item cleanly");

    a_header_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_record_kind == cdl_pkg::KIND_HEADER && !o_overlong_error) |->
            (o_member_index == '0 && o_access_flags == '0 && o_code_off == '0))
        else $error("header record carries entry fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(out_rec)))
        else $error("stalled output word changed or dropped");
`endif

endmodule
